// File: src/psq_pkg.sv
// Shared types, constants and note tables for the pitch scale quantizer.
package psq_pkg;

  localparam int MAX_OCTAVE = 10;
  localparam int NUM_SCALES = 16;
  localparam int MAX_STEPS  = 12;

  localparam int TABLE_ROWS = 16;
  localparam int TABLE_COLS = 12;

  localparam int FREQ_W = 32;
  localparam int F2_W   = FREQ_W + 1;   // input in Q16.17
  localparam int NOTE_W = 21;           // largest note fits in 21 bits
  localparam int MID_W  = NOTE_W + 1;   // sum of two notes
  localparam int IDX_W  = 4;
  localparam int OCT_W  = 4;
  localparam int SCL_W  = 4;
  localparam int DZ_BASE_W = 14;
  localparam int DZ_W   = DZ_BASE_W + MAX_OCTAVE - 1;
  localparam int SHV_W  = NOTE_W + (1 << OCT_W) - 1;

  localparam logic [DZ_BASE_W-1:0] DEAD_ZONE_Q17 = 14'd13107;
  localparam logic [OCT_W-1:0]     OCT_LAST      = OCT_W'(MAX_OCTAVE - 1);

  localparam logic [NOTE_W-1:0] N_C  = 21'd1071619;
  localparam logic [NOTE_W-1:0] N_CS = 21'd1135340;
  localparam logic [NOTE_W-1:0] N_D  = 21'd1202849;
  localparam logic [NOTE_W-1:0] N_DS = 21'd1274376;
  localparam logic [NOTE_W-1:0] N_E  = 21'd1350154;
  localparam logic [NOTE_W-1:0] N_F  = 21'd1430438;
  localparam logic [NOTE_W-1:0] N_FS = 21'd1515497;
  localparam logic [NOTE_W-1:0] N_G  = 21'd1605614;
  localparam logic [NOTE_W-1:0] N_GS = 21'd1701089;
  localparam logic [NOTE_W-1:0] N_A  = 21'd1802240;
  localparam logic [NOTE_W-1:0] N_AS = 21'd1909407;
  localparam logic [NOTE_W-1:0] N_B  = 21'd2022945;
  localparam logic [NOTE_W-1:0] N_0  = 21'd0;

  localparam logic [NOTE_W-1:0] NOTE_ROM [TABLE_ROWS][TABLE_COLS] = '{
    '{N_0, N_0, N_0, N_0, N_0, N_0, N_0, N_0, N_0, N_0, N_0, N_0},
    '{N_C, N_D, N_E, N_F, N_G, N_A, N_B, N_0, N_0, N_0, N_0, N_0},
    '{N_C, N_D, N_DS, N_F, N_G, N_GS, N_B, N_0, N_0, N_0, N_0, N_0},
    '{N_C, N_CS, N_D, N_DS, N_E, N_F, N_FS, N_G, N_GS, N_A, N_AS, N_B},
    '{N_C, N_D, N_E, N_G, N_A, N_0, N_0, N_0, N_0, N_0, N_0, N_0},
    '{N_C, N_DS, N_F, N_G, N_AS, N_0, N_0, N_0, N_0, N_0, N_0, N_0},
    '{N_C, N_D, N_DS, N_F, N_FS, N_GS, N_A, N_B, N_0, N_0, N_0, N_0},
    '{N_C, N_CS, N_DS, N_E, N_FS, N_G, N_A, N_AS, N_0, N_0, N_0, N_0},
    '{N_C, N_D, N_E, N_FS, N_G, N_A, N_B, N_0, N_0, N_0, N_0, N_0},
    '{N_C, N_D, N_E, N_F, N_G, N_A, N_AS, N_0, N_0, N_0, N_0, N_0},
    '{N_C, N_D, N_DS, N_F, N_G, N_A, N_AS, N_0, N_0, N_0, N_0, N_0},
    '{N_C, N_CS, N_DS, N_F, N_FS, N_GS, N_AS, N_0, N_0, N_0, N_0, N_0},
    '{N_C, N_D, N_DS, N_F, N_G, N_GS, N_AS, N_0, N_0, N_0, N_0, N_0},
    '{N_C, N_D, N_E, N_F, N_G, N_GS, N_A, N_B, N_0, N_0, N_0, N_0},
    '{N_C, N_D, N_DS, N_E, N_F, N_G, N_A, N_AS, N_0, N_0, N_0, N_0},
    '{N_C, N_D, N_DS, N_F, N_G, N_GS, N_B, N_0, N_0, N_0, N_0, N_0}
  };

  localparam logic [IDX_W-1:0] STEP_COUNT [TABLE_ROWS] = '{
    4'd1, 4'd7, 4'd7, 4'd12, 4'd5, 4'd5, 4'd8, 4'd8,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd7
  };

  typedef struct packed {
    logic [SCL_W-1:0]  scale;
    logic [FREQ_W-1:0] freq_in;
  } psq_in_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_out;
    logic [IDX_W-1:0]  note;
    logic [OCT_W-1:0]  octave;
    logic              snapped;
  } psq_out_t;

  // Operands for the shared subtract/compare unit.
  typedef struct packed {
    logic [F2_W-1:0] a;
    logic [F2_W-1:0] b;
  } cmp_req_t;

  // lt: a < b; diff: b - a (meaningful when lt).
  typedef struct packed {
    logic            lt;
    logic [F2_W-1:0] diff;
  } cmp_rsp_t;

  // Number of notes kept for a scale.
  function automatic logic [IDX_W-1:0] steps_of(input logic [SCL_W-1:0] s);
    logic [IDX_W-1:0] n;
    begin
      n = STEP_COUNT[s];
      if (32'(n) > MAX_STEPS) n = IDX_W'(MAX_STEPS);
      if (32'(n) > TABLE_COLS) n = IDX_W'(TABLE_COLS);
      if (n == '0) n = IDX_W'(1);
      return n;
    end
  endfunction

  function automatic logic [NOTE_W-1:0] note_val(input logic [SCL_W-1:0] s,
                                                 input logic [IDX_W-1:0] k);
    logic [NOTE_W-1:0] v;
    begin
      v = '0;
      if (32'(k) < TABLE_COLS) v = NOTE_ROM[s][k];
      return v;
    end
  endfunction

  // Midpoint of note k in Q5.17: sum of the note and its upper neighbor.
  function automatic logic [MID_W-1:0] mid_q17(input logic [SCL_W-1:0] s,
                                               input logic [IDX_W-1:0] k,
                                               input logic [IDX_W-1:0] n);
    logic [MID_W-1:0] lo;
    logic [MID_W-1:0] hi;
    begin
      lo = MID_W'(note_val(s, k));
      if (({1'b0, k} + 5'd1) < {1'b0, n}) begin
        hi = MID_W'(note_val(s, k + IDX_W'(1)));
      end else begin
        hi = {note_val(s, '0), 1'b0};
      end
      return lo + hi;
    end
  endfunction

endpackage

// File: src/psq_cmp.sv
// Shared subtract and compare unit for the quantizer sequencer.
module psq_cmp
  import psq_pkg::*;
(
  input  cmp_req_t req_i,
  output cmp_rsp_t rsp_o
);

  logic [F2_W:0] d;

  assign d           = {1'b0, req_i.b} - {1'b0, req_i.a};
  assign rsp_o.diff  = d[F2_W-1:0];
  assign rsp_o.lt    = ~d[F2_W] & (|d[F2_W-1:0]);

endmodule

// File: src/psq_core.sv
// Sequencer for the quantizer: octave search, note search and dead zone check.
module psq_core
  import psq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  psq_in_t  in_data_i,
  output logic     in_stall_o,
  output logic     res_valid_o,
  output psq_out_t res_data_o,
  input  logic     res_ready_i,
  output cmp_req_t cmp_req_o,
  input  cmp_rsp_t cmp_rsp_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OCT,
    ST_NOTE,
    ST_DZ,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [SCL_W-1:0]  scale_q, scale_d;
  logic [FREQ_W-1:0] fin_q, fin_d;
  logic [IDX_W-1:0]  n_q, n_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [OCT_W-1:0]  oct_q, oct_d;
  logic [F2_W-1:0]   high_q, high_d;
  logic [DZ_W-1:0]   dz_q, dz_d;
  logic [F2_W-1:0]   diff_q, diff_d;
  logic              snapped_q, snapped_d;

  logic [IDX_W-1:0]  n_in;
  logic [F2_W-1:0]   f2;
  logic [F2_W-1:0]   mid_sh;
  logic [SHV_W-1:0]  note_sh;

  assign f2     = {fin_q, 1'b0};
  assign n_in   = steps_of(in_data_i.scale);
  assign mid_sh = F2_W'(mid_q17(scale_q, k_q, n_q)) << oct_q;

  always_comb begin
    state_d   = state_q;
    scale_d   = scale_q;
    fin_d     = fin_q;
    n_d       = n_q;
    k_d       = k_q;
    oct_d     = oct_q;
    high_d    = high_q;
    dz_d      = dz_q;
    diff_d    = diff_q;
    snapped_d = snapped_q;
    cmp_req_o = '{a: f2, b: high_q};

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          scale_d   = in_data_i.scale;
          fin_d     = in_data_i.freq_in;
          n_d       = n_in;
          k_d       = '0;
          oct_d     = '0;
          high_d    = F2_W'(mid_q17(in_data_i.scale, n_in - IDX_W'(1), n_in));
          dz_d      = DZ_W'(DEAD_ZONE_Q17);
          snapped_d = 1'b0;
          if (in_data_i.scale != '0 && 32'(in_data_i.scale) < NUM_SCALES) begin
            state_d = ST_OCT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_OCT: begin
        // input at or above the top midpoint: climb one octave, or stop in the top octave
        cmp_req_o = '{a: f2, b: high_q};
        if (!cmp_rsp_i.lt) begin
          if (oct_q == OCT_LAST) begin
            state_d = ST_DONE;
          end else begin
            oct_d  = oct_q + OCT_W'(1);
            high_d = high_q << 1;
            dz_d   = dz_q << 1;
          end
        end else begin
          state_d = ST_NOTE;
        end
      end
      ST_NOTE: begin
        cmp_req_o = '{a: f2, b: mid_sh};
        if (cmp_rsp_i.lt) begin
          diff_d  = cmp_rsp_i.diff;
          state_d = ST_DZ;
        end else if (k_q == n_q - IDX_W'(1)) begin
          state_d = ST_DONE;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_DZ: begin
        // snap only when the distance is outside the dead zone
        cmp_req_o = '{a: F2_W'(dz_q), b: diff_q};
        snapped_d = cmp_rsp_i.lt;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scale_q   <= '0;
      fin_q     <= '0;
      n_q       <= '0;
      k_q       <= '0;
      oct_q     <= '0;
      high_q    <= '0;
      dz_q      <= '0;
      diff_q    <= '0;
      snapped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scale_q   <= scale_d;
      fin_q     <= fin_d;
      n_q       <= n_d;
      k_q       <= k_d;
      oct_q     <= oct_d;
      high_q    <= high_d;
      dz_q      <= dz_d;
      diff_q    <= diff_d;
      snapped_q <= snapped_d;
    end
  end

  assign note_sh     = SHV_W'(note_val(scale_q, k_q)) << oct_q;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    if (snapped_q) begin
      res_data_o.freq_out = (|note_sh[SHV_W-1:FREQ_W]) ? '1 : note_sh[FREQ_W-1:0];
      res_data_o.note     = k_q;
      res_data_o.octave   = oct_q;
      res_data_o.snapped  = 1'b1;
    end else begin
      res_data_o.freq_out = fin_q;
      res_data_o.note     = '0;
      res_data_o.octave   = '0;
      res_data_o.snapped  = 1'b0;
    end
  end

endmodule

// File: src/pitch_scale_quantizer.sv
// Top level of the pitch scale quantizer: sequencer, shared compare unit, output register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one transaction per
//   frequency: a scale number and an unsigned Q16.16 frequency. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns exactly one transaction per input:
//   the snapped frequency, note index, octave and a snapped flag. Scale zero, an
//   octave at or above the top octave, or an input inside the dead zone return the
//   input frequency unchanged with flag, note and octave at zero.
//   Sequence: one transaction takes a capture step, then up to MAX_OCTAVE octave
//   steps, up to twelve note compares and one dead zone compare, all on the single
//   shared subtract/compare unit, and a hand-off step into the output register.
//   Scale zero skips the searches and goes straight to the hand-off. in_stall_o stays high until the result moves
//   into the output register; the next transaction may then start while that
//   result still waits for the receiver.
//   If the receiver stalls, the output register holds its transaction and the
//   sequencer holds a second finished result until the register frees up.
//   Reset (rst_ni low, asynchronous) drops any work in flight and empties the
//   output register.
module pitch_scale_quantizer
  import psq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  psq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output psq_out_t out_data_o
);

  logic     res_valid;
  logic     res_ready;
  psq_out_t res_data;
  cmp_req_t cmp_req;
  cmp_rsp_t cmp_rsp;

  logic     out_valid_q, out_valid_d;
  psq_out_t out_data_q, out_data_d;

  psq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .res_ready_i (res_ready),
    .cmp_req_o   (cmp_req),
    .cmp_rsp_i   (cmp_rsp)
  );

  psq_cmp u_cmp (
    .req_i (cmp_req),
    .rsp_o (cmp_rsp)
  );

  // Load the output register whenever it is empty or being drained this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) out_data_d = res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Pass-through results carry no note or octave.
  a_pass_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.snapped |-> out_data_o.note == '0 && out_data_o.octave == '0)
    else $error("pass-through result with nonzero note or octave");

  a_oct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.snapped |-> 32'(out_data_o.octave) < MAX_OCTAVE)
    else $error("snapped result with octave out of range");

  a_note_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.snapped |-> 32'(out_data_o.note) < MAX_STEPS)
    else $error("snapped result with note out of range");

  // A finished result waiting on the output register must be held intact.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("sequencer dropped or changed a waiting result");

  // The sequencer takes no new transaction while a result is pending.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("input accepted while a result is pending");

endmodule
